[sv/assert_macros.svh]
// Assertion macros used by sparse_zero_reclaim_block_store.
// Each macro checks a property on the rising clock edge and is disabled during reset.
// The checks compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SZR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("%m failed");
`define SZR_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error("%m failed");
`else
`define SZR_ASSERT(label, clk, rst, prop)
`define SZR_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[sv/szr_pkg.sv]
// ----------------------------------------------------------------------------
// szr_pkg
// Types and constants for the thin-provisioned word store.
// ----------------------------------------------------------------------------
`default_nettype none
package szr_pkg;
   localparam int ADDR_W         = 19;
   localparam int DATA_W         = 64;
   localparam int VOL_W          = 11;
   localparam int USE_W          = 9;
   localparam int LOGICAL_BLOCKS = 1024;
   localparam int FRAMES         = 256;
   localparam int BLOCK_WORDS    = 512;
   localparam int WORD_W   = $clog2(BLOCK_WORDS);
   localparam int BLK_W    = $clog2(LOGICAL_BLOCKS);
   localparam int BLKNUM_W = ADDR_W - WORD_W;
   localparam int FRAME_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int FD_DEPTH = FRAMES * BLOCK_WORDS;
   localparam int FD_AW    = FRAME_W + WORD_W;
   localparam int CNT_W    = $clog2(FRAMES + 1);
   localparam int NZ_W     = $clog2(BLOCK_WORDS + 1);
   localparam int MAP_W    = FRAME_W + 1;
   localparam int CLR_DEPTH = (FD_DEPTH > LOGICAL_BLOCKS) ? FD_DEPTH : LOGICAL_BLOCKS;
   localparam int CLR_W    = $clog2(CLR_DEPTH);
   localparam logic [VOL_W-1:0] VOL_RESET = VOL_W'(1024);

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_TRIM  = 2'd2;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_NOFRAME = 2'd1;
   localparam logic [1:0] STAT_RANGE   = 2'd2;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [ADDR_W-1:0] word_address;
      logic [DATA_W-1:0] write_data;
      logic              burst_last;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [1:0]        status;
      logic [USE_W-1:0]  blocks_in_use;
      logic              request_done;
   } rsp_type;
endpackage
`default_nettype wire

[sv/szr_ram.sv]
// ----------------------------------------------------------------------------
// szr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module szr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_ff <= mem_ff[raddr];
   end

   assign rdata = rd_ff;
endmodule
`default_nettype wire

[sv/sparse_zero_reclaim_block_store.sv]
// ----------------------------------------------------------------------------
// sparse_zero_reclaim_block_store
// Thin-provisioned 64-bit word store that maps logical blocks to frames on
// the first nonzero write and returns a frame to the pool when it is all zero.
//
// A request is taken when start is high and busy is low. Each request gives
// exactly one response, shown on rsp_item for one cycle with rsp_valid high;
// the receiver cannot stall it. A request that is out of range or an unused
// command is answered from the idle state; a read, a zero write or a dropped
// write to a block with no frame is answered after the block map read; any
// other request goes on to the frame word and nonzero counter read and the
// write back, or to the frame allocation, which writes the word. Each response
// is registered; the next request is taken in the cycle the response is shown.
// After reset, busy stays high while every memory is swept one entry a cycle:
// frame words cleared, map unmapped, counters zeroed and the free stack
// filled. Writes of csr_wdata with csr_we are taken at any time and are
// meant for idle periods.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sparse_zero_reclaim_block_store
   import szr_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire req_type          req_item,
   output logic                  rsp_valid,
   output rsp_type               rsp_item,
   input  wire logic             csr_we,
   input  wire logic [VOL_W-1:0] csr_wdata
);
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MAP   = 2'd1;
   localparam logic [1:0] S_ALLOC = 2'd2;
   localparam logic [1:0] S_RMW   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic              clr_active_ff, clr_active_in;
   logic [CLR_W-1:0]  clr_ff, clr_in;
   logic [VOL_W-1:0]  volume_ff;
   logic [1:0]        cmd_ff, cmd_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [BLK_W-1:0]  blk_ff, blk_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic              last_ff, last_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [CNT_W-1:0]  free_count_ff, free_count_in;
   logic [CNT_W-1:0]  in_use_ff, in_use_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              map_we, fd_we, nz_we, ff_we;
   logic [BLK_W-1:0]  map_waddr, map_raddr;
   logic [MAP_W-1:0]  map_wdata, map_rdata;
   logic [FD_AW-1:0]  fd_waddr, fd_raddr;
   logic [DATA_W-1:0] fd_wdata, fd_rdata;
   logic [FRAME_W-1:0] nz_waddr, nz_raddr, ff_waddr, ff_raddr;
   logic [NZ_W-1:0]   nz_wdata, nz_rdata, nz_next;
   logic [FRAME_W-1:0] ff_wdata, ff_rdata;

   logic [BLKNUM_W-1:0] blknum;
   logic                accept;
   logic                out_of_range;

   assign accept = start && !busy;
   assign blknum = req_item.word_address[ADDR_W-1:WORD_W];
   assign out_of_range = (32'(blknum) >= 32'(volume_ff)) ||
                         (32'(blknum) >= LOGICAL_BLOCKS);

   always_comb begin
      state_in      = state_ff;
      clr_active_in = clr_active_ff;
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      word_in       = word_ff;
      blk_in        = blk_ff;
      val_in        = val_ff;
      last_in       = last_ff;
      frame_in      = frame_ff;
      free_count_in = free_count_ff;
      in_use_in     = in_use_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      map_we = 1'b0;  map_waddr = blk_ff;  map_wdata = '0;  map_raddr = blk_ff;
      fd_we  = 1'b0;  fd_waddr = {frame_ff, word_ff};  fd_wdata = '0;
      fd_raddr = {frame_ff, word_ff};
      nz_we  = 1'b0;  nz_waddr = frame_ff;  nz_wdata = '0;  nz_raddr = frame_ff;
      ff_we  = 1'b0;  ff_waddr = free_count_ff[FRAME_W-1:0];  ff_wdata = frame_ff;
      ff_raddr = FRAME_W'(free_count_ff - CNT_W'(1));
      nz_next = nz_rdata;

      if (clr_active_ff) begin
         fd_we     = 32'(clr_ff) < FD_DEPTH;
         fd_waddr  = FD_AW'(clr_ff);
         fd_wdata  = '0;
         map_we    = 32'(clr_ff) < LOGICAL_BLOCKS;
         map_waddr = BLK_W'(clr_ff);
         map_wdata = '0;
         nz_we     = 32'(clr_ff) < FRAMES;
         nz_waddr  = FRAME_W'(clr_ff);
         nz_wdata  = '0;
         ff_we     = 32'(clr_ff) < FRAMES;
         ff_waddr  = FRAME_W'(clr_ff);
         ff_wdata  = FRAME_W'(FRAMES - 1 - 32'(clr_ff));
         clr_in    = clr_ff + CLR_W'(1);
         if (clr_ff == CLR_W'(CLR_DEPTH - 1)) begin
            clr_active_in = 1'b0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cmd_in  = req_item.cmd;
                  word_in = req_item.word_address[WORD_W-1:0];
                  blk_in  = blknum[BLK_W-1:0];
                  val_in  = (req_item.cmd == CMD_WRITE) ? req_item.write_data : '0;
                  last_in = req_item.burst_last;
                  map_raddr = blknum[BLK_W-1:0];
                  rsp_in.read_data     = '0;
                  rsp_in.status        = STAT_OK;
                  rsp_in.blocks_in_use = USE_W'(in_use_ff);
                  rsp_in.request_done  = req_item.burst_last;
                  if (out_of_range) begin
                     rsp_in.status = STAT_RANGE;
                     rsp_valid_in  = 1'b1;
                  end else if (req_item.cmd == CMD_READ || req_item.cmd == CMD_WRITE ||
                               req_item.cmd == CMD_TRIM) begin
                     state_in = S_MAP;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end
            end
            S_MAP: begin
               if (map_rdata[FRAME_W]) begin
                  frame_in = map_rdata[FRAME_W-1:0];
                  fd_raddr = {map_rdata[FRAME_W-1:0], word_ff};
                  nz_raddr = map_rdata[FRAME_W-1:0];
                  state_in = S_RMW;
               end else if (cmd_ff == CMD_READ || val_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else if (free_count_ff == '0) begin
                  rsp_in.status = STAT_NOFRAME;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_ALLOC;
               end
            end
            S_ALLOC: begin
               frame_in  = ff_rdata;
               map_we    = 1'b1;
               map_wdata = {1'b1, ff_rdata};
               fd_we     = 1'b1;
               fd_waddr  = {ff_rdata, word_ff};
               fd_wdata  = val_ff;
               nz_we     = 1'b1;
               nz_waddr  = ff_rdata;
               nz_wdata  = NZ_W'(1);
               free_count_in = free_count_ff - CNT_W'(1);
               in_use_in     = in_use_ff + CNT_W'(1);
               rsp_in.blocks_in_use = USE_W'(in_use_ff + CNT_W'(1));
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
            S_RMW: begin
               if (cmd_ff == CMD_READ) begin
                  rsp_in.read_data = fd_rdata;
               end else begin
                  if (fd_rdata == '0 && val_ff != '0) begin
                     nz_next = nz_rdata + NZ_W'(1);
                  end else if (fd_rdata != '0 && val_ff == '0 && nz_rdata != '0) begin
                     nz_next = nz_rdata - NZ_W'(1);
                  end
                  fd_we    = 1'b1;
                  fd_wdata = val_ff;
                  nz_we    = 1'b1;
                  nz_wdata = nz_next;
                  if (nz_next == '0) begin
                     map_we    = 1'b1;
                     map_wdata = '0;
                     if (32'(free_count_ff) < FRAMES) begin
                        ff_we         = 1'b1;
                        free_count_in = free_count_ff + CNT_W'(1);
                     end
                     if (in_use_ff != '0) begin
                        in_use_in = in_use_ff - CNT_W'(1);
                        rsp_in.blocks_in_use = USE_W'(in_use_ff - CNT_W'(1));
                     end
                  end
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         clr_active_ff <= 1'b1;
         clr_ff        <= '0;
         volume_ff     <= VOL_RESET;
         free_count_ff <= CNT_W'(FRAMES);
         in_use_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_active_ff <= clr_active_in;
         clr_ff        <= clr_in;
         free_count_ff <= free_count_in;
         in_use_ff     <= in_use_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            volume_ff <= csr_wdata;
         end
      end
      cmd_ff   <= cmd_in;
      word_ff  <= word_in;
      blk_ff   <= blk_in;
      val_ff   <= val_in;
      last_ff  <= last_in;
      frame_ff <= frame_in;
      rsp_ff   <= rsp_in;
   end

   szr_ram #(.WIDTH(MAP_W), .DEPTH(LOGICAL_BLOCKS)) u_map (
      .clock(clock), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
      .raddr(map_raddr), .rdata(map_rdata));

   szr_ram #(.WIDTH(DATA_W), .DEPTH(FD_DEPTH)) u_frame_data (
      .clock(clock), .we(fd_we), .waddr(fd_waddr), .wdata(fd_wdata),
      .raddr(fd_raddr), .rdata(fd_rdata));

   szr_ram #(.WIDTH(NZ_W), .DEPTH(FRAMES)) u_nonzero (
      .clock(clock), .we(nz_we), .waddr(nz_waddr), .wdata(nz_wdata),
      .raddr(nz_raddr), .rdata(nz_rdata));

   szr_ram #(.WIDTH(FRAME_W), .DEPTH(FRAMES)) u_free_stack (
      .clock(clock), .we(ff_we), .waddr(ff_waddr), .wdata(ff_wdata),
      .raddr(ff_raddr), .rdata(ff_rdata));

   assign busy      = clr_active_ff || (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `SZR_ASSERT(a_pool_balance, clock, reset, (32'(free_count_ff) + 32'(in_use_ff)) == FRAMES)
   `SZR_ASSERT(a_no_rsp_in_clear, clock, reset, !(clr_active_ff && rsp_valid_ff))
   `SZR_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy || rsp_valid_ff)
   `SZR_ASSERT_NEXT(a_done_echo, clock, reset, state_ff == S_RMW && !clr_active_ff,
                    rsp_valid_ff && rsp_item.request_done == $past(last_ff))
endmodule
`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking test of the thin-provisioned word store. Every request is
// run through a behavioral copy of the block map, frame pool and nonzero
// counters, and each response is compared with the predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import szr_pkg::*;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_item;
   logic             rsp_valid;
   rsp_type          rsp_item;
   logic             csr_we;
   logic [VOL_W-1:0] csr_wdata;

   sparse_zero_reclaim_block_store DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   logic [DATA_W-1:0] word_mem [int];
   logic [FRAME_W-1:0] frame_of [LOGICAL_BLOCKS];
   bit                 mapped [LOGICAL_BLOCKS];
   int unsigned        nz_count [FRAMES];
   int unsigned        pool [FRAMES];
   int unsigned        pool_depth;
   int unsigned        frames_used;
   int unsigned        vol_blocks;

   rsp_type pending_rsp [$];
   int      mismatches;
   int      sender_idle;
   int      hot_blocks;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("status: fail");
      $finish;
   end

   function automatic rsp_type store_model(req_type r);
      rsp_type           o;
      int unsigned       blk, wrd, fr, slot;
      logic [DATA_W-1:0] val, old;
      o = '0;
      blk = r.word_address / BLOCK_WORDS;
      wrd = r.word_address % BLOCK_WORDS;
      if (blk >= vol_blocks || blk >= LOGICAL_BLOCKS) begin
         o.status = STAT_RANGE;
      end else if (r.cmd == CMD_READ) begin
         if (mapped[blk]) begin
            slot = frame_of[blk] * BLOCK_WORDS + wrd;
            if (word_mem.exists(slot)) o.read_data = word_mem[slot];
         end
      end else if (r.cmd == CMD_WRITE || r.cmd == CMD_TRIM) begin
         val = (r.cmd == CMD_WRITE) ? r.write_data : '0;
         if (mapped[blk]) begin
            fr = frame_of[blk];
            slot = fr * BLOCK_WORDS + wrd;
            old = word_mem.exists(slot) ? word_mem[slot] : '0;
            if (old == 0 && val != 0) nz_count[fr]++;
            else if (old != 0 && val == 0 && nz_count[fr] > 0) nz_count[fr]--;
            word_mem[slot] = val;
            if (nz_count[fr] == 0) begin
               mapped[blk] = 0;
               if (pool_depth < FRAMES) begin
                  pool[pool_depth] = fr;
                  pool_depth++;
               end
               if (frames_used > 0) frames_used--;
            end
         end else if (val != 0) begin
            if (pool_depth == 0) begin
               o.status = STAT_NOFRAME;
            end else begin
               pool_depth--;
               fr = pool[pool_depth];
               frame_of[blk] = fr;
               mapped[blk] = 1;
               word_mem[fr * BLOCK_WORDS + wrd] = val;
               nz_count[fr] = 1;
               frames_used++;
            end
         end
      end
      o.blocks_in_use = frames_used[USE_W-1:0];
      o.request_done = r.burst_last;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", rsp_item);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_item !== e) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", e, rsp_item);
            end
         end
      end
   end

   task automatic send_request(logic [1:0] cmd, int unsigned addr,
                               logic [DATA_W-1:0] data, logic last);
      req_type r;
      r.cmd = cmd;
      r.word_address = addr[ADDR_W-1:0];
      r.write_data = data;
      r.burst_last = last;
      while (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(store_model(r));
   endtask

   task automatic drain;
      start <= 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_volume(int unsigned v);
      drain();
      csr_we <= 1;
      csr_wdata <= v[VOL_W-1:0];
      @(posedge clock);
      csr_we <= 0;
      vol_blocks = v;
   endtask

   function automatic logic [DATA_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   task automatic test_directed;
      set_volume(1024);
      send_request(CMD_READ, 0, '0, 1);
      send_request(CMD_WRITE, 0, '1, 0);
      send_request(CMD_READ, 0, '0, 1);
      send_request(CMD_WRITE, 511, 64'h8000_0000_0000_0001, 1);
      send_request(CMD_WRITE, 0, '0, 0);
      send_request(CMD_TRIM, 511, '1, 1);
      send_request(CMD_READ, 511, '0, 0);
      send_request(CMD_WRITE, 700, '0, 1);
      send_request(CMD_TRIM, 900, '0, 1);
      send_request(2'd3, 1000, '1, 1);
      send_request(CMD_WRITE, 524287, '1, 1);
      send_request(CMD_READ, 524287, '0, 0);
      set_volume(1);
      send_request(CMD_WRITE, 512, '1, 1);
      send_request(CMD_WRITE, 5, 64'h55, 1);
      send_request(CMD_READ, 5, '0, 1);
      send_request(CMD_TRIM, 5, '0, 1);
      set_volume(0);
      send_request(CMD_READ, 0, '0, 1);
      set_volume(2047);
      send_request(CMD_READ, 524287, '0, 1);
      send_request(CMD_TRIM, 524287, '0, 1);
   endtask

   task automatic test_pool_exhaust;
      set_volume(1024);
      for (int b = 0; b < FRAMES + 4; b++)
         send_request(CMD_WRITE, b * BLOCK_WORDS + (b % BLOCK_WORDS), rand_word() | 1,
                      $urandom_range(1));
      for (int b = FRAMES + 3; b >= 0; b--)
         send_request(CMD_TRIM, b * BLOCK_WORDS + (b % BLOCK_WORDS), '0, 1);
   endtask

   task automatic test_random(int count, int idle);
      int unsigned blk, wrd, c, v;
      logic [DATA_W-1:0] d;
      sender_idle = idle;
      for (int i = 0; i < count; i++) begin
         if ((i % 100) == 0) begin
            v = $urandom_range(3) == 0 ? $urandom_range(2047) : 1024;
            set_volume(v);
         end
         blk = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(hot_blocks);
         if ($urandom_range(19) == 0) blk = $urandom_range(1024, 2047);
         wrd = $urandom_range(3) == 0 ? $urandom_range(511) : $urandom_range(7);
         c = $urandom_range(99);
         d = rand_word();
         if ($urandom_range(2) == 0) d = '0;
         send_request(c < 35 ? CMD_READ : c < 75 ? CMD_WRITE : c < 95 ? CMD_TRIM : 2'd3,
                      blk * BLOCK_WORDS + wrd, d, $urandom_range(1));
      end
      sender_idle = 0;
   endtask

   initial begin
      reset = 1;
      start = 0;
      req_item = '0;
      csr_we = 0;
      csr_wdata = VOL_RESET;
      mismatches = 0;
      sender_idle = 0;
      hot_blocks = 15;
      for (int i = 0; i < LOGICAL_BLOCKS; i++) begin
         mapped[i] = 0;
         frame_of[i] = '0;
      end
      for (int i = 0; i < FRAMES; i++) begin
         nz_count[i] = 0;
         pool[i] = FRAMES - 1 - i;
      end
      pool_depth = FRAMES;
      frames_used = 0;
      vol_blocks = 1024;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      while (busy) @(posedge clock);
      test_directed();
      test_pool_exhaust();
      test_random(270, 0);
      drain();
      test_random(270, 79);
      hot_blocks = 300;
      test_random(270, 21);
      hot_blocks = 15;
      test_random(270, 0);
      drain();
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire
